[rtl/core/lckp_pkg.sv]
package lckp_pkg;

  localparam int LINE_CAPACITY_DEFAULT = 10;

  // Command codes as shown on command_code.
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_FORWARD  = 3'd1;
  localparam logic [2:0] CMD_BACKWARD = 3'd2;
  localparam logic [2:0] CMD_STOP     = 3'd3;
  localparam logic [2:0] CMD_STATUS   = 3'd4;
  localparam logic [2:0] CMD_SPEED    = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN  = 3'd6;

  // Status codes as shown on status_code.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [8:0] SPEED_SAT = 9'd256;
  localparam logic [8:0] SPEED_MAX = 9'd255;

  // Keywords, first character in element 0, padded with zero bytes.
  localparam logic [0:7][7:0] KW_FORWARD  = {"FORWARD", 8'h00};
  localparam logic [0:7][7:0] KW_BACKWARD = "BACKWARD";
  localparam logic [0:7][7:0] KW_STOP     = {"STOP", 32'h0};
  localparam logic [0:7][7:0] KW_STATUS   = {"STATUS", 16'h0};
  localparam logic [0:7][7:0] KW_SPEED    = {"SPEED ", 16'h0};

  localparam int KW_FORWARD_LEN  = 7;
  localparam int KW_BACKWARD_LEN = 8;
  localparam int KW_STOP_LEN     = 4;
  localparam int KW_STATUS_LEN   = 6;
  localparam int KW_SPEED_LEN    = 6;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_EOL,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

endpackage

[rtl/core/lckp_front.sv]
module lckp_front (
  input  logic               in_valid,
  input  logic               action,
  input  logic [7:0]         rx_byte,
  input  logic               q_full,
  output logic               in_stall,
  output logic               push,
  output lckp_pkg::item_t    item
);
  import lckp_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    item.data = rx_byte;
    if (action) begin
      item.kind = KIND_CLEAR;
    end else if (rx_byte == CHAR_LF || rx_byte == CHAR_CR) begin
      item.kind = KIND_EOL;
    end else begin
      item.kind = KIND_CHAR;
    end
  end

endmodule

[rtl/core/lckp_queue.sv]
module lckp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lckp_pkg::item_t    push_item,
  input  logic               pop,
  output logic               q_valid,
  output logic               q_full,
  output lckp_pkg::item_t    head
);
  import lckp_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_valid = (count != 2'd0);
  assign q_full  = (count == 2'd2);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/lckp_back.sv]
module lckp_back #(
  parameter int LINE_CAPACITY = lckp_pkg::LINE_CAPACITY_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  lckp_pkg::item_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         command_code,
  output logic [1:0]         status_code,
  output logic [7:0]         speed_value,
  output logic               command_ready
);
  import lckp_pkg::*;

  localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
  localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

  // The line is parsed as it is received: each appended character updates
  // the keyword prefix flags and the speed argument, so a line end only has
  // to read these flags.
  logic [LEN_W-1:0] line_length, line_length_next;
  logic [LEN_W-1:0] text_length, text_length_next;
  logic             zero_seen, zero_seen_next;
  logic             fw_ok, fw_ok_next;
  logic             bw_ok, bw_ok_next;
  logic             stop_ok, stop_ok_next;
  logic             stat_ok, stat_ok_next;
  logic             spd_ok, spd_ok_next;
  logic             digits_ok, digits_ok_next;
  logic [8:0]       speed_acc, speed_acc_next;
  logic [2:0]       command_next;
  logic [1:0]       status_next;
  logic [7:0]       speed_next;
  logic             ready_next;
  logic             out_valid_next;

  logic             stored;
  logic             grows;
  logic             is_digit;
  logic [11:0]      product;
  logic [2:0]       kw_idx;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    line_length_next = line_length;
    text_length_next = text_length;
    zero_seen_next   = zero_seen;
    fw_ok_next       = fw_ok;
    bw_ok_next       = bw_ok;
    stop_ok_next     = stop_ok;
    stat_ok_next     = stat_ok;
    spd_ok_next      = spd_ok;
    digits_ok_next   = digits_ok;
    speed_acc_next   = speed_acc;
    command_next     = command_code;
    status_next      = status_code;
    speed_next       = speed_value;
    ready_next       = command_ready;
    out_valid_next   = pop || (out_valid && out_stall);

    stored   = (head.kind == KIND_CHAR) && (line_length < CAP);
    grows    = stored && !zero_seen && (head.data != CHAR_NUL);
    is_digit = (head.data >= CHAR_ZERO) && (head.data <= CHAR_NINE);
    kw_idx   = text_length[2:0];
    product  = 12'(speed_acc) * 12'd10 + 12'(head.data - CHAR_ZERO);

    if (pop) begin
      case (head.kind)
        KIND_CLEAR: begin
          command_next     = CMD_NONE;
          status_next      = ST_OK;
          speed_next       = 8'd0;
          ready_next       = 1'b0;
          line_length_next = '0;
          text_length_next = '0;
          zero_seen_next   = 1'b0;
          fw_ok_next       = 1'b1;
          bw_ok_next       = 1'b1;
          stop_ok_next     = 1'b1;
          stat_ok_next     = 1'b1;
          spd_ok_next      = 1'b1;
          digits_ok_next   = 1'b1;
          speed_acc_next   = 9'd0;
        end
        KIND_CHAR: begin
          if (!stored) begin
            status_next = ST_OVERFLOW;
          end else begin
            line_length_next = line_length + LEN_W'(1);
            if (head.data == CHAR_NUL) begin
              zero_seen_next = 1'b1;
            end
          end
          if (grows) begin
            text_length_next = text_length + LEN_W'(1);
            if (text_length < LEN_W'(KW_FORWARD_LEN) && head.data != KW_FORWARD[kw_idx]) begin
              fw_ok_next = 1'b0;
            end
            if (text_length < LEN_W'(KW_BACKWARD_LEN) && head.data != KW_BACKWARD[kw_idx]) begin
              bw_ok_next = 1'b0;
            end
            if (text_length < LEN_W'(KW_STOP_LEN) && head.data != KW_STOP[kw_idx]) begin
              stop_ok_next = 1'b0;
            end
            if (text_length < LEN_W'(KW_STATUS_LEN) && head.data != KW_STATUS[kw_idx]) begin
              stat_ok_next = 1'b0;
            end
            if (text_length < LEN_W'(KW_SPEED_LEN)) begin
              if (head.data != KW_SPEED[kw_idx]) begin
                spd_ok_next = 1'b0;
              end
            end else if (!is_digit) begin
              digits_ok_next = 1'b0;
            end else if (product > 12'(SPEED_SAT)) begin
              speed_acc_next = SPEED_SAT;
            end else begin
              speed_acc_next = product[8:0];
            end
          end
        end
        KIND_EOL: begin
          if (line_length != '0) begin
            ready_next = 1'b1;
            if (status_code == ST_OVERFLOW) begin
              command_next = CMD_UNKNOWN;
            end else begin
              command_next = CMD_UNKNOWN;
              status_next  = ST_INVALID;
              speed_next   = 8'd0;
              if (fw_ok && text_length == LEN_W'(KW_FORWARD_LEN)) begin
                command_next = CMD_FORWARD;
                status_next  = ST_OK;
              end else if (bw_ok && text_length == LEN_W'(KW_BACKWARD_LEN)) begin
                command_next = CMD_BACKWARD;
                status_next  = ST_OK;
              end else if (stop_ok && text_length == LEN_W'(KW_STOP_LEN)) begin
                command_next = CMD_STOP;
                status_next  = ST_OK;
              end else if (stat_ok && text_length == LEN_W'(KW_STATUS_LEN)) begin
                command_next = CMD_STATUS;
                status_next  = ST_OK;
              end else if (spd_ok && text_length > LEN_W'(KW_SPEED_LEN) && digits_ok
                           && speed_acc <= SPEED_MAX) begin
                command_next = CMD_SPEED;
                status_next  = ST_OK;
                speed_next   = speed_acc[7:0];
              end
            end
          end
        end
        default: begin
          command_next = command_code;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length   <= '0;
      text_length   <= '0;
      zero_seen     <= 1'b0;
      fw_ok         <= 1'b1;
      bw_ok         <= 1'b1;
      stop_ok       <= 1'b1;
      stat_ok       <= 1'b1;
      spd_ok        <= 1'b1;
      digits_ok     <= 1'b1;
      speed_acc     <= 9'd0;
      command_code  <= CMD_NONE;
      status_code   <= ST_OK;
      speed_value   <= 8'd0;
      command_ready <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      line_length   <= line_length_next;
      text_length   <= text_length_next;
      zero_seen     <= zero_seen_next;
      fw_ok         <= fw_ok_next;
      bw_ok         <= bw_ok_next;
      stop_ok       <= stop_ok_next;
      stat_ok       <= stat_ok_next;
      spd_ok        <= spd_ok_next;
      digits_ok     <= digits_ok_next;
      speed_acc     <= speed_acc_next;
      command_code  <= command_next;
      status_code   <= status_next;
      speed_value   <= speed_next;
      command_ready <= ready_next;
      out_valid     <= out_valid_next;
    end
  end

endmodule

[rtl/core/line_command_keyword_parser_unit.sv]
// Line command parser for a received character stream.
//
// Input channel (in_valid / in_stall): one beat carries either a received
// byte (action = 0) or a clear request (action = 1). CR and LF end a line;
// any other byte is appended to the line while it has room.
// Output channel (out_valid / out_stall): every input beat gives exactly one
// output beat with the held command, status, speed and ready flag after it.
//
// An accepted beat is written into the queue, then registered in the
// executing stage. Throughput is one beat per cycle while the receiver does
// not stall; the keyword compare and speed argument are built up as
// characters arrive, so a line end costs no more than any other byte. A
// two-entry queue sits between the classifier and the executing stage.
// While the receiver stalls, the output beat holds, the queue fills and
// in_stall rises once both entries are taken.
// Reset empties the queue and the line, clears the command to none, the
// status to ok, the speed to zero and drops the ready flag.
module line_command_keyword_parser_unit #(
  parameter int LINE_CAPACITY = lckp_pkg::LINE_CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] command_code,
  output logic [1:0] status_code,
  output logic [7:0] speed_value,
  output logic       command_ready
);
  import lckp_pkg::*;

  logic  push;
  logic  pop;
  logic  q_valid;
  logic  q_full;
  item_t push_item;
  item_t head;

  lckp_front u_front (
    .in_valid (in_valid),
    .action   (action),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .item     (push_item)
  );

  lckp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head      (head)
  );

  lckp_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command_code  (command_code),
    .status_code   (status_code),
    .speed_value   (speed_value),
    .command_ready (command_ready)
  );

endmodule

[rtl/core/lckp_checker.sv]
module lckp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] command_code,
  input logic [1:0] status_code,
  input logic [7:0] speed_value,
  input logic       command_ready
);
  import lckp_pkg::*;

  // A stalled output beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(command_code) && $stable(status_code)
      && $stable(speed_value) && $stable(command_ready))
    else $error("output beat changed while stalled");

  // Nothing is decoded yet, so no command, no invalid status and no speed.
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !command_ready |-> command_code == CMD_NONE && status_code != ST_INVALID
      && speed_value == 8'd0)
    else $error("decoded state shown without ready");

  // A successful decode always names a real command.
  a_ok_command: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_ready && status_code == ST_OK |->
      command_code != CMD_NONE && command_code != CMD_UNKNOWN)
    else $error("ok status with no recognised command");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat present after reset");

endmodule

bind line_command_keyword_parser_unit lckp_checker u_lckp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .command_code  (command_code),
  .status_code   (status_code),
  .speed_value   (speed_value),
  .command_ready (command_ready)
);

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import lckp_pkg::*;

  localparam int LINE_CAP = LINE_CAPACITY_DEFAULT;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD = 150;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [2:0] cmd;
    logic [1:0] st;
    logic [7:0] spd;
    logic       rdy;
  } held_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       action = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] command_code;
  logic [1:0] status_code;
  logic [7:0] speed_value;
  logic       command_ready;

  // Parser state as the block should hold it.
  logic [7:0] line_buf [LINE_CAP];
  int         line_len = 0;
  logic [2:0] model_cmd = CMD_NONE;
  logic [1:0] model_st = ST_OK;
  logic [7:0] model_spd = 8'h00;
  logic       model_rdy = 1'b0;

  held_result_t pending_results[$];

  int  error_count = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  int  hold_request = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  bit  offering = 1'b0;

  line_command_keyword_parser_unit #(
    .LINE_CAPACITY(LINE_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .command_code(command_code),
    .status_code(status_code),
    .speed_value(speed_value),
    .command_ready(command_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit held_text_is(string kw, int tlen);
    if (tlen < kw.len()) return 1'b0;
    for (int i = 0; i < kw.len(); i++) begin
      if (line_buf[i] != kw[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void decode_held_line();
    int tlen;
    int num;
    bit digits_ok;
    tlen = 0;
    // The text stops at the first zero byte.
    while (tlen < line_len && line_buf[tlen] != CHAR_NUL) tlen++;
    model_spd = 8'h00;
    model_cmd = CMD_UNKNOWN;
    model_st = ST_INVALID;
    if (tlen == 7 && held_text_is("FORWARD", tlen)) begin
      model_cmd = CMD_FORWARD;
      model_st = ST_OK;
    end else if (tlen == 8 && held_text_is("BACKWARD", tlen)) begin
      model_cmd = CMD_BACKWARD;
      model_st = ST_OK;
    end else if (tlen == 4 && held_text_is("STOP", tlen)) begin
      model_cmd = CMD_STOP;
      model_st = ST_OK;
    end else if (tlen == 6 && held_text_is("STATUS", tlen)) begin
      model_cmd = CMD_STATUS;
      model_st = ST_OK;
    end else if (tlen > 6 && held_text_is("SPEED ", tlen)) begin
      num = 0;
      digits_ok = 1'b1;
      for (int i = 6; i < tlen; i++) begin
        if (line_buf[i] < CHAR_ZERO || line_buf[i] > CHAR_NINE) begin
          digits_ok = 1'b0;
        end else if (digits_ok) begin
          // Saturating at 256 keeps long digit strings invalid.
          num = num * 10 + int'(line_buf[i] - CHAR_ZERO);
          if (num > 256) num = 256;
        end
      end
      if (digits_ok && num <= 255) begin
        model_spd = num[7:0];
        model_cmd = CMD_SPEED;
        model_st = ST_OK;
      end
    end
  endfunction

  function automatic void track_parser_beat(logic act, logic [7:0] b);
    held_result_t r;
    if (act) begin
      model_cmd = CMD_NONE;
      model_spd = 8'h00;
      model_rdy = 1'b0;
      model_st = ST_OK;
      line_len = 0;
    end else if (b != CHAR_LF && b != CHAR_CR) begin
      if (line_len < LINE_CAP) begin
        line_buf[line_len] = b;
        line_len++;
      end else begin
        model_st = ST_OVERFLOW;
      end
    end else if (line_len > 0) begin
      if (model_st == ST_OVERFLOW) model_cmd = CMD_UNKNOWN;
      else decode_held_line();
      model_rdy = 1'b1;
    end
    r.cmd = model_cmd;
    r.st = model_st;
    r.spd = model_spd;
    r.rdy = model_rdy;
    pending_results.push_back(r);
  endfunction

  task automatic send_beat(logic act, logic [7:0] b);
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 7);
      end
      burst_left--;
    end
    if (gap > 0) begin
      if (offering) in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    rx_byte <= b;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_parser_beat(act, b);
    items_sent++;
  endtask

  task automatic idle_input();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_clear();
    send_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_bytes(byte_q_t text);
    foreach (text[i]) send_beat(1'b0, text[i]);
  endtask

  function automatic byte_q_t bytes_of(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] random_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF || b == CHAR_CR);
    return b;
  endfunction

  function automatic string pick_keyword();
    case ($urandom_range(0, 3))
      0: return "FORWARD";
      1: return "BACKWARD";
      2: return "STOP";
      default: return "STATUS";
    endcase
  endfunction

  function automatic byte_q_t speed_line();
    int val;
    string digits;
    case ($urandom_range(0, 3))
      0: val = $urandom_range(0, 255);
      1: val = $urandom_range(250, 260);
      2: val = $urandom_range(0, 9999);
      default: val = $urandom_range(0, 999);
    endcase
    digits = $sformatf("%0d", val);
    if ($urandom_range(0, 5) == 0) digits = {"0", digits};
    return bytes_of({"SPEED ", digits});
  endfunction

  function automatic byte_q_t bad_speed_line();
    case ($urandom_range(0, 4))
      0: return bytes_of("SPEED");
      1: return bytes_of("SPEED ");
      2: return bytes_of("SPEED 1A");
      3: return bytes_of("SPEED  5");
      default: return bytes_of("SPEEDY");
    endcase
  endfunction

  task automatic send_random_line();
    byte_q_t text;
    int pos;
    case ($urandom_range(0, 9))
      0, 1: text = bytes_of(pick_keyword());
      2, 3: text = speed_line();
      4: text = bad_speed_line();
      5: begin
        text = bytes_of(pick_keyword());
        pos = $urandom_range(0, text.size() - 1);
        text[pos] = random_text_byte();
      end
      6: begin
        // A zero byte hides whatever follows it from the decoder.
        text = ($urandom_range(0, 1) == 0) ? bytes_of(pick_keyword()) : speed_line();
        text.push_back(CHAR_NUL);
        repeat ($urandom_range(0, 2)) text.push_back(random_text_byte());
      end
      7: repeat ($urandom_range(1, 14)) text.push_back(random_text_byte());
      8: begin
        text = bytes_of(pick_keyword());
        if ($urandom_range(0, 1) == 0) void'(text.pop_back());
        else text.push_back(random_text_byte());
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          text = bytes_of(pick_keyword());
          foreach (text[i]) text[i] = text[i] + 8'h20;
        end
      end
    endcase
    send_bytes(text);
    send_beat(1'b0, ($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF);
    if ($urandom_range(0, 4) == 0) send_beat(1'b0, CHAR_LF);
    if ($urandom_range(0, 99) < 65) send_clear();
  endtask

  // Short known lines: the STOP and SPEED paths, an unknown byte, the zero-byte
  // case and a line end on an empty line.
  task automatic test_directed_cases();
    send_clear();
    send_beat(1'b0, CHAR_LF);
    send_bytes(bytes_of("STOP"));
    send_beat(1'b0, CHAR_CR);
    send_beat(1'b0, 8'hff);
    send_beat(1'b0, CHAR_LF);
    send_clear();
    send_beat(1'b0, CHAR_NUL);
    send_beat(1'b0, CHAR_CR);
    send_clear();
    send_bytes(bytes_of("SPEED 99"));
    send_beat(1'b0, CHAR_LF);
    drain_results();
  endtask

  task automatic test_random_commands(int item_goal);
    while (items_sent < item_goal) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      send_random_line();
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  task automatic test_random_noise(int count);
    logic [7:0] b;
    string noise_chars;
    noise_chars = " 0123DEOPS";
    repeat (count) begin
      case ($urandom_range(0, 3))
        0, 1: b = 8'($urandom_range(0, 255));
        2: b = ($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF;
        default: b = 8'(noise_chars[$urandom_range(0, 9)]);
      endcase
      send_beat(($urandom_range(0, 99) < 8), b);
    end
    drain_results();
  endtask

  // The receiver holds off while beats keep coming, so the block fills and
  // has to stall its input.
  task automatic test_backpressure();
    int goal;
    drain_results();
    goal = items_sent + 40;
    gaps_on = 1'b0;
    hold_request = LONG_HOLD;
    while (items_sent < goal) send_random_line();
    gaps_on = 1'b1;
    drain_results();
  endtask

  always @(posedge clk) begin : receiver_pattern
    int hold_left;
    int seg_left;
    int stall_pct;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (seg_left == 0) begin
      seg_left = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    seg_left--;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    held_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: command_code=%0d status_code=%0d", command_code,
               status_code);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (command_code !== want.cmd) begin
          $error("command_code: expected %0d, got %0d", want.cmd, command_code);
          error_count++;
        end
        if (status_code !== want.st) begin
          $error("status_code: expected %0d, got %0d", want.st, status_code);
          error_count++;
        end
        if (speed_value !== want.spd) begin
          $error("speed_value: expected %0d, got %0d", want.spd, speed_value);
          error_count++;
        end
        if (command_ready !== want.rdy) begin
          $error("command_ready: expected %0d, got %0d", want.rdy, command_ready);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_backpressure();
    test_random_commands(780);
    test_random_noise(170);
    idle_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[line_command_keyword_parser_unit.f]
rtl/core/lckp_pkg.sv
rtl/core/lckp_front.sv
rtl/core/lckp_queue.sv
rtl/core/lckp_back.sv
rtl/core/line_command_keyword_parser_unit.sv
rtl/core/lckp_checker.sv
bench/testbench.sv
